// File: sv/crrs_pkg.sv
// Shared types and constants for the credit round-robin scheduler.
`timescale 1ns / 1ps
`default_nettype none

package crrs_pkg;

    localparam int unsigned MASK_W          = 8;
    localparam int unsigned TASK_IDX_W      = 3;
    localparam int unsigned CREDIT_W        = 4;
    localparam int unsigned CFG_IDX_W       = 4;
    localparam int unsigned NUM_CREDIT_REGS = 8;

    typedef logic [CREDIT_W-1:0]   credit_t;
    typedef logic [TASK_IDX_W-1:0] task_idx_t;

    // Scheduler state carried from one tick to the next.
    typedef struct packed {
        logic      active;
        task_idx_t current_index;
        credit_t   remaining_slots;
    } sched_state_t;

    // One grant result.
    typedef struct packed {
        logic      grant_valid;
        task_idx_t grant_index;
    } grant_t;

endpackage

`default_nettype wire

// File: sv/crrs_credit_regs.sv
// Per-task credit register file, written through the config port.
`timescale 1ns / 1ps
`default_nettype none

module crrs_credit_regs #(
    parameter int NUM_TASKS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [crrs_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire crrs_pkg::credit_t              wr_data,
    output crrs_pkg::credit_t                   credits [NUM_TASKS]
);

    crrs_pkg::credit_t credits_reg [NUM_TASKS];

    // Indexes past the task count (or past the register list) are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                credits_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (wr_index == crrs_pkg::CFG_IDX_W'(i))
                begin
                    credits_reg[i] <= wr_data;
                end
            end
        end
    end

    assign credits = credits_reg;

endmodule

`default_nettype wire

// File: sv/crrs_pick.sv
// Combinational grant decision and next-state logic for one tick.
`timescale 1ns / 1ps
`default_nettype none

module crrs_pick #(
    parameter int NUM_TASKS = 8
) (
    input  wire logic [crrs_pkg::MASK_W-1:0] ready_mask,
    input  wire crrs_pkg::credit_t           credits [NUM_TASKS],
    input  wire crrs_pkg::sched_state_t      state,
    output crrs_pkg::sched_state_t           state_next,
    output crrs_pkg::grant_t                 grant
);

    logic [crrs_pkg::TASK_IDX_W:0] start;
    logic                          found;
    crrs_pkg::task_idx_t           found_idx;
    crrs_pkg::credit_t             found_credit;
    crrs_pkg::credit_t             dec_slots;

    assign dec_slots = state.remaining_slots - crrs_pkg::CREDIT_W'(1);

    // Scan origin: zero when idle, one past the current task otherwise.
    assign start = state.active
        ? ({1'b0, state.current_index} + (crrs_pkg::TASK_IDX_W + 1)'(1))
        : '0;

    // Priority encoder over ready tasks with nonzero credit at or above start.
    always_comb
    begin
        found        = 1'b0;
        found_idx    = '0;
        found_credit = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (!found && ready_mask[i] && (credits[i] != '0)
                && ((crrs_pkg::TASK_IDX_W + 1)'(i) >= start))
            begin
                found        = 1'b1;
                found_idx    = crrs_pkg::TASK_IDX_W'(i);
                found_credit = credits[i];
            end
        end
    end

    always_comb
    begin
        state_next = '0;
        grant      = '0;
        if (state.active && (dec_slots != '0))
        begin
            // Turn continues regardless of the ready bit.
            state_next.active          = 1'b1;
            state_next.current_index   = state.current_index;
            state_next.remaining_slots = dec_slots;
            grant.grant_valid          = 1'b1;
            grant.grant_index          = state.current_index;
        end
        else if (found)
        begin
            state_next.active          = 1'b1;
            state_next.current_index   = found_idx;
            state_next.remaining_slots = found_credit;
            grant.grant_valid          = 1'b1;
            grant.grant_index          = found_idx;
        end
    end

endmodule

`default_nettype wire

// File: sv/credit_round_robin_scheduler.sv
// Top level of the credit-based weighted round-robin scheduler.
// Path: the edge that accepts a tick loads the tick register, and its grant lands in
// the output register (tick register, then grant register); held back under stall.
// Throughput: one tick per cycle unless the output stalls; the grant
// decision is a single priority encoder pass from tick to grant register.
// Reset: rst_n (async, active low) clears all credits to 0, the scheduler
// state to idle, and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module credit_round_robin_scheduler #(
    parameter int NUM_TASKS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Tick input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [crrs_pkg::MASK_W-1:0]    ready_mask,
    // Grant output channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                grant_valid,
    output logic [crrs_pkg::TASK_IDX_W-1:0]     grant_index,
    // Credit configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [crrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crrs_pkg::CREDIT_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Credit registers. Config is always taken; write only while
    // no tick is in flight (the block does not enforce it), so no decision hazard.
    // A write during a turn leaves the loaded slot counter alone.
    // ------------------------------------------------------------------
    crrs_pkg::credit_t credits [NUM_TASKS];

    assign cfg_ready = 1'b1;

    crrs_credit_regs #(
        .NUM_TASKS (NUM_TASKS)
    ) u_credit_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .credits  (credits)
    );

    // ------------------------------------------------------------------
    // Pipeline: tick register -> decision -> grant register.
    // The stage advances when a tick is held and the grant register is
    // empty or being drained this cycle; scheduler state updates on the
    // same edge, so back-to-back ticks see each other's state.
    // ------------------------------------------------------------------
    logic                           in_valid_reg;
    logic [crrs_pkg::MASK_W-1:0]    mask_reg;
    logic                           out_valid_reg;
    crrs_pkg::grant_t               grant_reg;
    crrs_pkg::sched_state_t         state_reg;

    crrs_pkg::sched_state_t         state_next;
    crrs_pkg::grant_t               grant_next;
    logic                           advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    crrs_pick #(
        .NUM_TASKS (NUM_TASKS)
    ) u_pick (
        .ready_mask (mask_reg),
        .credits    (credits),
        .state      (state_reg),
        .state_next (state_next),
        .grant      (grant_next)
    );

    // Control state: valid flags and the scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mask_reg <= ready_mask;
        end
        if (advance)
        begin
            grant_reg <= grant_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign grant_valid = grant_reg.grant_valid;
    assign grant_index = grant_reg.grant_index;

endmodule

`default_nettype wire
